[sv/rpfp_pkg.sv]
// Shared types and constants for the radar presence frame parser.
package rpfp_pkg;

  localparam int unsigned COUNTER_BITS = 16;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned CMP_W        = (COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W;
  localparam int unsigned DIST_W       = 16;

  localparam logic [7:0] HDR_BYTE  = 8'hAA;
  localparam logic [7:0] TAIL_BYTE = 8'h55;
  localparam logic [7:0] TYPE_NONE   = 8'h00;
  localparam logic [7:0] TYPE_MOVING = 8'h01;
  localparam logic [7:0] TYPE_MICRO  = 8'h02;

  localparam logic [CFG_W-1:0] PUBLISH_INTERVAL_RST = CFG_W'(1000);
  localparam logic [CFG_W-1:0] SILENCE_TIMEOUT_RST  = CFG_W'(1000);

  // Register indexes on the config port
  localparam logic REG_PUBLISH_INTERVAL = 1'b0;
  localparam logic REG_SILENCE_TIMEOUT  = 1'b1;

  // Input word kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Position inside a frame, after the header
  localparam logic [2:0] POS_TYPE   = 3'd0;
  localparam logic [2:0] POS_DIST_L = 3'd1;
  localparam logic [2:0] POS_DIST_H = 3'd2;
  localparam logic [2:0] POS_TAIL_0 = 3'd3;

  typedef enum logic [1:0] {
    CAUSE_REPORT   = 2'd0,
    CAUSE_TIMEOUT  = 2'd1,
    CAUSE_BAD_TAIL = 2'd2
  } cause_e;

  typedef struct packed {
    cause_e              cause;
    logic                present;
    logic                moving;
    logic                micro;
    logic [DIST_W-1:0]   distance_cm;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] publish_interval;
    logic [CFG_W-1:0] silence_timeout;
  } cfg_t;

endpackage

[sv/rpfp_if.sv]
// Channel interfaces: input words, result words, config writes.
interface rpfp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;
  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface rpfp_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   cause;
  logic                         present;
  logic                         moving;
  logic                         micro;
  logic [rpfp_pkg::DIST_W-1:0]  distance_cm;
  modport source (output valid, output cause, output present, output moving,
                  output micro, output distance_cm, input ready);
  modport sink   (input valid, input cause, input present, input moving,
                  input micro, input distance_cm, output ready);
endinterface

interface rpfp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic                        idx;
  logic [rpfp_pkg::CFG_W-1:0]  data;
  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

[sv/rpfp_parser.sv]
// Frame parser state, silence/report counters and per-word result logic.
module rpfp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              kind_i,
  input  logic [7:0]        rx_byte_i,
  input  rpfp_pkg::cfg_t    cfg_i,
  output logic              res_valid_o,
  output rpfp_pkg::result_t res_o
);

  localparam logic [rpfp_pkg::COUNTER_BITS-1:0] CNT_MAX = '1;

  logic                               in_frame_q, in_frame_d;
  logic                               last_hdr_q, last_hdr_d;
  logic [2:0]                         pos_q, pos_d;
  logic [7:0]                         type_q, type_d;
  logic [rpfp_pkg::DIST_W-1:0]        dist_q, dist_d;
  logic                               tail_ok_q, tail_ok_d;
  logic [rpfp_pkg::COUNTER_BITS-1:0]  since_good_q, since_good_d;
  logic [rpfp_pkg::COUNTER_BITS-1:0]  since_rpt_q, since_rpt_d;
  logic [2:0]                         held_q, held_d;

  logic [rpfp_pkg::COUNTER_BITS-1:0]  since_good_inc, since_rpt_inc;
  logic [2:0]                         new_flags;

  assign since_good_inc = (since_good_q == CNT_MAX) ? since_good_q : since_good_q + 1'b1;
  assign since_rpt_inc  = (since_rpt_q == CNT_MAX) ? since_rpt_q : since_rpt_q + 1'b1;

  // bit0 present, bit1 moving, bit2 micro
  assign new_flags = {type_q == rpfp_pkg::TYPE_MICRO,
                      type_q == rpfp_pkg::TYPE_MOVING,
                      type_q != rpfp_pkg::TYPE_NONE};

  always_comb begin
    in_frame_d   = in_frame_q;
    last_hdr_d   = last_hdr_q;
    pos_d        = pos_q;
    type_d       = type_q;
    dist_d       = dist_q;
    tail_ok_d    = tail_ok_q;
    since_good_d = since_good_q;
    since_rpt_d  = since_rpt_q;
    held_d       = held_q;
    res_valid_o  = 1'b0;
    res_o.cause       = rpfp_pkg::CAUSE_REPORT;
    res_o.present     = 1'b0;
    res_o.moving      = 1'b0;
    res_o.micro       = 1'b0;
    res_o.distance_cm = '0;

    if (kind_i == rpfp_pkg::KIND_TICK) begin
      since_good_d = since_good_inc;
      since_rpt_d  = since_rpt_inc;
      if ((rpfp_pkg::CMP_W'(since_good_inc) > rpfp_pkg::CMP_W'(cfg_i.silence_timeout))
          && (held_q != 3'b000)) begin
        held_d      = 3'b000;
        res_valid_o = 1'b1;
        res_o.cause = rpfp_pkg::CAUSE_TIMEOUT;
      end
    end else if (!in_frame_q) begin
      if (last_hdr_q && rx_byte_i == rpfp_pkg::HDR_BYTE) begin
        in_frame_d = 1'b1;
        last_hdr_d = 1'b0;
        pos_d      = rpfp_pkg::POS_TYPE;
      end else begin
        last_hdr_d = (rx_byte_i == rpfp_pkg::HDR_BYTE);
      end
    end else begin
      case (pos_q)
        rpfp_pkg::POS_TYPE: begin
          type_d = rx_byte_i;
          pos_d  = rpfp_pkg::POS_DIST_L;
        end
        rpfp_pkg::POS_DIST_L: begin
          dist_d = {dist_q[15:8], rx_byte_i};
          pos_d  = rpfp_pkg::POS_DIST_H;
        end
        rpfp_pkg::POS_DIST_H: begin
          dist_d = {rx_byte_i, dist_q[7:0]};
          pos_d  = rpfp_pkg::POS_TAIL_0;
        end
        rpfp_pkg::POS_TAIL_0: begin
          tail_ok_d = (rx_byte_i == rpfp_pkg::TAIL_BYTE);
          pos_d     = pos_q + 3'd1;
        end
        default: begin
          // last tail byte closes the frame either way
          in_frame_d = 1'b0;
          last_hdr_d = 1'b0;
          pos_d      = rpfp_pkg::POS_TYPE;
          if (!(tail_ok_q && rx_byte_i == rpfp_pkg::TAIL_BYTE)) begin
            res_valid_o = 1'b1;
            res_o.cause = rpfp_pkg::CAUSE_BAD_TAIL;
          end else begin
            since_good_d = '0;
            if (rpfp_pkg::CMP_W'(since_rpt_q) >= rpfp_pkg::CMP_W'(cfg_i.publish_interval))
            begin
              since_rpt_d       = '0;
              held_d            = new_flags;
              res_valid_o       = 1'b1;
              res_o.present     = new_flags[0];
              res_o.moving      = new_flags[1];
              res_o.micro       = new_flags[2];
              res_o.distance_cm = dist_q;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q   <= 1'b0;
      last_hdr_q   <= 1'b0;
      pos_q        <= rpfp_pkg::POS_TYPE;
      tail_ok_q    <= 1'b0;
      since_good_q <= '0;
      since_rpt_q  <= '0;
      held_q       <= 3'b000;
    end else if (accept_i) begin
      in_frame_q   <= in_frame_d;
      last_hdr_q   <= last_hdr_d;
      pos_q        <= pos_d;
      tail_ok_q    <= tail_ok_d;
      since_good_q <= since_good_d;
      since_rpt_q  <= since_rpt_d;
      held_q       <= held_d;
    end
  end

  // frame payload, always written before it is used
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      type_q <= type_d;
      dist_q <= dist_d;
    end
  end

endmodule

[sv/radar_presence_frame_parser_top.sv]
// Top level: radar presence frame parser with config registers and output skid.
// A result word is registered in the output register, or in the skid if stalled.
// Throughput: one input word per cycle; the output register plus a one-word
//   skid stage keep input ready high until two results wait unconsumed.
// Reset: asynchronous active-low; parser state, counters and held flags clear,
//   both config registers return to 1000, output and skid go empty.
module radar_presence_frame_parser_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  rpfp_in_if.sink      in_i,
  rpfp_cfg_if.sink     cfg_i,
  rpfp_out_if.source   out_o
);

  rpfp_pkg::cfg_t     cfg_q;
  logic               in_accept;
  logic               res_valid;
  rpfp_pkg::result_t  res;

  logic               out_valid_q, skid_valid_q;
  rpfp_pkg::result_t  out_q, skid_q;
  logic               out_free;

  // Config writes are always taken; idle-only use is the caller's concern.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.publish_interval <= rpfp_pkg::PUBLISH_INTERVAL_RST;
      cfg_q.silence_timeout  <= rpfp_pkg::SILENCE_TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.idx == rpfp_pkg::REG_PUBLISH_INTERVAL) begin
        cfg_q.publish_interval <= cfg_i.data;
      end else begin
        cfg_q.silence_timeout <= cfg_i.data;
      end
    end
  end

  // Input is taken whenever the skid slot is empty, so a new word can come in
  // while a finished result still sits in the output register.
  assign in_i.ready = !skid_valid_q;
  assign in_accept  = in_i.valid && !skid_valid_q;

  rpfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .kind_i      (in_i.kind),
    .rx_byte_i   (in_i.rx_byte),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register drains first; skid catches a result while it is stalled.
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_accept && res_valid;
      end
    end else if (in_accept && res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_accept && res_valid) begin
        out_q <= res;
      end
    end else if (in_accept && res_valid) begin
      skid_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.cause       = out_q.cause;
  assign out_o.present     = out_q.present;
  assign out_o.moving      = out_q.moving;
  assign out_o.micro       = out_q.micro;
  assign out_o.distance_cm = out_q.distance_cm;

endmodule
